// File: hdl/sfr_pkg.sv
// Shared constants for the status frame receiver: framing bytes, ids and status codes.
package sfr_pkg;

  // Framing
  localparam logic [7:0] StartByte  = 8'hAA;
  localparam int unsigned MaxPayload = 252;
  localparam logic [7:0] MaxLength  = 8'(MaxPayload + 1);
  localparam int unsigned HeadDepth  = 14;
  localparam int unsigned HeadIdxW   = $clog2(HeadDepth);

  // Response and notification ids
  localparam logic [7:0] IdAck       = 8'h80;
  localparam logic [7:0] IdNak       = 8'h81;
  localparam logic [7:0] IdStatus    = 8'h82;
  localparam logic [7:0] IdPosition  = 8'h83;
  localparam logic [7:0] IdThreshold = 8'h84;
  localparam logic [7:0] IdPong      = 8'h85;
  localparam logic [7:0] IdTemp      = 8'h86;
  localparam logic [7:0] IdPot       = 8'h87;
  localparam logic [7:0] IdMoveDone  = 8'hA0;
  localparam logic [7:0] IdHomed     = 8'hA1;
  localparam logic [7:0] IdCalib     = 8'hA2;
  localparam logic [7:0] IdErrNotify = 8'hAF;

  // Minimum frame lengths (id plus payload bytes)
  localparam logic [7:0] LenStatus   = 8'd15;
  localparam logic [7:0] LenPosition = 8'd7;
  localparam logic [7:0] LenOneByte  = 8'd2;
  localparam logic [7:0] LenTemp     = 8'd9;
  localparam logic [7:0] LenPot      = 8'd4;

  // Frame status codes
  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusChecksum = 2'd1,
    StatusUnknown  = 2'd2,
    StatusShort    = 2'd3
  } frame_status_e;

endpackage

// File: hdl/status_frame_receiver.sv
// Status frame receiver: byte-wise frame parser with XOR check and cached status registers.
// Result: a frame's result is registered and valid in the cycle after its check byte is accepted.
// Throughput: one byte per cycle; only a check byte waits while a result is still unread.
// Reset: asynchronous, active low; parser returns to hunting and all caches read zero.
// Cache registers drive the result fields directly; they change only when a result is issued.
module status_frame_receiver
  import sfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         frame_status_o,
  output logic [7:0]         response_id_o,
  output logic [15:0]        motor_state_error_o,
  output logic [2:0]         status_flags_o,
  output logic signed [31:0] motor_position_o,
  output logic signed [15:0] position_tenths_o,
  output logic [31:0]        travel_length_o,
  output logic signed [7:0]  stall_level_o,
  output logic [7:0]         nak_code_o,
  output logic [7:0]         reported_error_o,
  output logic [63:0]        temperatures_raw_o,
  output logic [15:0]        pot_distance_mm_o
);

  typedef enum logic [2:0] {
    PhHunt,
    PhLen,
    PhId,
    PhData,
    PhCheck
  } phase_e;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  check_q, check_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  head_q [HeadDepth];

  // Caches
  logic [7:0]  mstate_q, mstate_d;
  logic [7:0]  merr_q, merr_d;
  logic [2:0]  flags_q, flags_d;
  logic [31:0] pos_q, pos_d;
  logic [15:0] pct_q, pct_d;
  logic [31:0] travel_q, travel_d;
  logic [7:0]  sgt_q, sgt_d;
  logic [7:0]  nak_q, nak_d;
  logic [31:0] tobj_q, tobj_d;
  logic [31:0] tamb_q, tamb_d;
  logic [15:0] pot_q, pot_d;

  // Result register; the id is held here so a following frame cannot disturb it
  logic          out_valid_q, out_valid_d;
  frame_status_e status_q, status_d;
  logic [7:0]    rep_q, rep_d;
  logic [7:0]    rid_q, rid_d;

  logic in_fire, result_fire, head_we;
  logic [8:0] count_inc;

  // A check byte needs a free result slot; every other byte is always taken
  assign in_ready_o  = (phase_q != PhCheck) || !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign result_fire = in_fire && (phase_q == PhCheck);
  assign count_inc   = {1'b0, count_q} + 9'd1;
  assign head_we     = in_fire && (phase_q == PhData) && (count_q < 8'(HeadDepth));

  // Parser next state
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    count_d = count_q;
    check_d = check_q;
    id_d    = id_q;
    if (in_fire) begin
      case (phase_q)
        PhHunt: begin
          if (rx_byte_i == StartByte) phase_d = PhLen;
        end
        PhLen: begin
          count_d = '0;
          if (rx_byte_i == 8'd0 || rx_byte_i > MaxLength) begin
            phase_d = PhHunt;
            len_d   = '0;
            check_d = '0;
          end else begin
            phase_d = PhId;
            len_d   = rx_byte_i;
            check_d = rx_byte_i;
          end
        end
        PhId: begin
          id_d    = rx_byte_i;
          check_d = check_q ^ rx_byte_i;
          phase_d = (len_q == 8'd1) ? PhCheck : PhData;
        end
        PhData: begin
          check_d = check_q ^ rx_byte_i;
          count_d = count_inc[7:0];
          if ((count_inc + 9'd1) >= {1'b0, len_q}) phase_d = PhCheck;
        end
        PhCheck: begin
          phase_d = PhHunt;
          len_d   = '0;
          count_d = '0;
          check_d = '0;
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  // Frame handling on the check byte
  always_comb begin
    mstate_d = mstate_q;
    merr_d   = merr_q;
    flags_d  = flags_q;
    pos_d    = pos_q;
    pct_d    = pct_q;
    travel_d = travel_q;
    sgt_d    = sgt_q;
    nak_d    = nak_q;
    tobj_d   = tobj_q;
    tamb_d   = tamb_q;
    pot_d    = pot_q;
    status_d = status_q;
    rep_d    = rep_q;
    rid_d    = rid_q;
    if (result_fire) begin
      rep_d    = '0;
      rid_d    = id_q;
      status_d = StatusOk;
      if (check_q != rx_byte_i) begin
        status_d = StatusChecksum;
      end else begin
        case (id_q)
          IdAck: nak_d = '0;
          IdNak: begin
            if (len_q < LenOneByte) status_d = StatusShort;
            else begin
              nak_d = head_q[0];
              rep_d = head_q[0];
            end
          end
          IdStatus: begin
            if (len_q < LenStatus) status_d = StatusShort;
            else begin
              mstate_d = head_q[0];
              merr_d   = head_q[1];
              flags_d  = {flags_q[2], head_q[2][1:0]};
              pos_d    = {head_q[6], head_q[5], head_q[4], head_q[3]};
              pct_d    = {head_q[8], head_q[7]};
              travel_d = {head_q[12], head_q[11], head_q[10], head_q[9]};
              sgt_d    = head_q[13];
            end
          end
          IdPosition: begin
            if (len_q < LenPosition) status_d = StatusShort;
            else begin
              pos_d = {head_q[3], head_q[2], head_q[1], head_q[0]};
              pct_d = {head_q[5], head_q[4]};
            end
          end
          IdThreshold: begin
            if (len_q < LenOneByte) status_d = StatusShort;
            else sgt_d = head_q[0];
          end
          IdPong, IdMoveDone: ;
          IdTemp: begin
            if (len_q < LenTemp) status_d = StatusShort;
            else begin
              tobj_d = {head_q[3], head_q[2], head_q[1], head_q[0]};
              tamb_d = {head_q[7], head_q[6], head_q[5], head_q[4]};
            end
          end
          IdPot: begin
            if (len_q < LenPot) status_d = StatusShort;
            else begin
              flags_d = {(head_q[0] != 8'd0), flags_q[1:0]};
              pot_d   = {head_q[2], head_q[1]};
            end
          end
          IdHomed: flags_d = flags_q | 3'b010;
          IdCalib: flags_d = flags_q | 3'b001;
          IdErrNotify: begin
            if (len_q < LenOneByte) status_d = StatusShort;
            else rep_d = head_q[0];
          end
          default: status_d = StatusUnknown;
        endcase
      end
    end
  end

  // Result valid: set by a check byte, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (result_fire) out_valid_d = 1'b1;
  end

  // Control and cache registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      len_q       <= '0;
      count_q     <= '0;
      check_q     <= '0;
      id_q        <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StatusOk;
      rep_q       <= '0;
      rid_q       <= '0;
      mstate_q    <= '0;
      merr_q      <= '0;
      flags_q     <= '0;
      pos_q       <= '0;
      pct_q       <= '0;
      travel_q    <= '0;
      sgt_q       <= '0;
      nak_q       <= '0;
      tobj_q      <= '0;
      tamb_q      <= '0;
      pot_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      count_q     <= count_d;
      check_q     <= check_d;
      id_q        <= id_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      rep_q       <= rep_d;
      rid_q       <= rid_d;
      mstate_q    <= mstate_d;
      merr_q      <= merr_d;
      flags_q     <= flags_d;
      pos_q       <= pos_d;
      pct_q       <= pct_d;
      travel_q    <= travel_d;
      sgt_q       <= sgt_d;
      nak_q       <= nak_d;
      tobj_q      <= tobj_d;
      tamb_q      <= tamb_d;
      pot_q       <= pot_d;
    end
  end

  // Payload head capture; no reset, entries are written before any read
  always_ff @(posedge clk_i) begin
    if (head_we) head_q[count_q[HeadIdxW-1:0]] <= rx_byte_i;
  end

  // Result fields
  assign out_valid_o         = out_valid_q;
  assign frame_status_o      = status_q;
  assign response_id_o       = rid_q;
  assign motor_state_error_o = {merr_q, mstate_q};
  assign status_flags_o      = flags_q;
  assign motor_position_o    = pos_q;
  assign position_tenths_o   = pct_q;
  assign travel_length_o     = travel_q;
  assign stall_level_o       = sgt_q;
  assign nak_code_o          = nak_q;
  assign reported_error_o    = rep_q;
  assign temperatures_raw_o  = {tamb_q, tobj_q};
  assign pot_distance_mm_o   = pot_q;

endmodule
